/* design/hcb_pkg.sv */
// shared constants for the huffman code builder
// no dependencies; imported by hcb_alu and huffman_code_builder
package hcb_pkg;

   localparam int FREQ_W          = 24;
   localparam int SYM_W           = 6;
   localparam int LEN_W           = 6;
   localparam int CODE_W          = 63;
   localparam int REQ_DATA_W      = 24;
   localparam int RSP_DATA_W      = 80;
   localparam int DEF_MAX_SYMBOLS = 64;

endpackage

/* design/hcb_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module hcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/hcb_alu.sv */
// shared frequency unit: node merge adder and sort-order compare
// depends on hcb_pkg
module hcb_alu #(
   parameter int SUM_W = 30
) (
   input  logic [SUM_W-1:0] a_freq,
   input  logic [SUM_W-1:0] b_freq,
   input  logic [SUM_W-1:0] key_freq,
   output logic [SUM_W-1:0] sum_freq,
   output logic             a_greater
);
   import hcb_pkg::*;

   // frequency sums of a full set never exceed the widened range
   assign sum_freq  = a_freq + b_freq;
   assign a_greater = (a_freq > key_freq);

endmodule

/* design/huffman_code_builder.sv */
// huffman code builder: loads frequencies, builds the tree, emits codes
// depends on hcb_pkg, hcb_ram and hcb_alu
// a load keeps req_tready low while its entry is inserted, scanning the sorted list from the tail
// and moving each larger entry up one place
// a build merges by a check, a read of the front two and an add, then the parent's sorted insert;
// one more check ends it, then a root step and a read, left, right step per merge label the tree
// results: each is read, loaded, then held until rsp_tready; req_tready is low until all are sent
// the sorted list sits in a single ram with one read port, one read per cycle
// reset: synchronous active-high reset empties the set; ram contents are not cleared
module huffman_code_builder #(
   parameter int MAX_SYMBOLS = hcb_pkg::DEF_MAX_SYMBOLS
) (
   input  logic                          clock,
   input  logic                          reset,
   // input stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [hcb_pkg::REQ_DATA_W-1:0] req_tdata,  // freq_value[23:0]
   input  logic                          req_tlast,   // last_symbol
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [hcb_pkg::RSP_DATA_W-1:0] rsp_tdata,  // symbol_index[5:0], code_length[11:6],
                                                      // code_bits[74:12], zero[79:75]
   output logic                          rsp_tlast,   // last_code
   output logic                          rsp_tuser    // overflow_flag
);
   import hcb_pkg::*;

   localparam int NODES  = 2 * MAX_SYMBOLS - 1;
   localparam int NODE_W = $clog2(NODES);
   localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
   localparam int CH_AW  = $clog2(MAX_SYMBOLS);
   localparam int SUM_W  = FREQ_W + $clog2(MAX_SYMBOLS);
   localparam int ENT_W  = NODE_W + SUM_W;
   localparam int CE_W   = LEN_W + CODE_W;

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_INS_RD    = 13'b0000000000010,
      ST_INS_CMP   = 13'b0000000000100,
      ST_MRG_CHK   = 13'b0000000001000,
      ST_MRG_A     = 13'b0000000010000,
      ST_MRG_B     = 13'b0000000100000,
      ST_CODE_INIT = 13'b0000001000000,
      ST_CODE_RD   = 13'b0000010000000,
      ST_CODE_L    = 13'b0000100000000,
      ST_CODE_R    = 13'b0001000000000,
      ST_EMIT_RD   = 13'b0010000000000,
      ST_EMIT_LD   = 13'b0100000000000,
      ST_EMIT_OUT  = 13'b1000000000000
   } state_type;

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;      // symbols in the set
   logic [CNT_W-1:0] len_ff, len_in;          // live entries of the sorted list
   logic [NODE_W-1:0] head_ff, head_in;       // front of the sorted list in ram
   logic [CNT_W-1:0] merge_ff, merge_in;      // merges done
   logic [CNT_W-1:0] walk_ff, walk_in;        // merge walked down, or symbol emitted
   logic             ovf_ff, ovf_in;
   logic             last_ff, last_in;        // last item seen, build pending
   logic             build_ff, build_in;      // insert belongs to the build phase
   logic             out_valid_ff, out_valid_in;

   // payload
   logic [NODE_W-1:0] pos_ff, pos_in;
   logic [NODE_W-1:0] key_node_ff, key_node_in;
   logic [SUM_W-1:0]  key_freq_ff, key_freq_in;
   logic [ENT_W-1:0]  a_ent_ff, a_ent_in;
   logic [CE_W-1:0]   par_ff, par_in;
   logic [NODE_W-1:0] right_ff, right_in;
   logic [SYM_W-1:0]  out_sym_ff, out_sym_in;
   logic [CE_W-1:0]   out_code_ff, out_code_in;
   logic              out_last_ff, out_last_in;
   logic              out_ovf_ff, out_ovf_in;

   // ram ports
   logic              srt_we;
   logic [NODE_W-1:0] srt_wa, srt_ra;
   logic [ENT_W-1:0]  srt_wd, srt_rd;
   logic              ch_we;
   logic [CH_AW-1:0]  ch_wa, ch_ra;
   logic [2*NODE_W-1:0] ch_wd, ch_rd;
   logic              cd_we;
   logic [NODE_W-1:0] cd_wa, cd_ra;
   logic [CE_W-1:0]   cd_wd, cd_rd;

   logic [SUM_W-1:0]  alu_a, alu_sum;
   logic              alu_gt;

   logic              req_xfer;
   logic [NODE_W-1:0] tail;

   hcb_ram #(.WIDTH(ENT_W), .DEPTH(NODES)) u_sorted_ram (
      .clock(clock), .wr_en(srt_we), .wr_addr(srt_wa), .wr_data(srt_wd),
      .rd_addr(srt_ra), .rd_data(srt_rd)
   );

   hcb_ram #(.WIDTH(2 * NODE_W), .DEPTH(MAX_SYMBOLS)) u_child_ram (
      .clock(clock), .wr_en(ch_we), .wr_addr(ch_wa), .wr_data(ch_wd),
      .rd_addr(ch_ra), .rd_data(ch_rd)
   );

   hcb_ram #(.WIDTH(CE_W), .DEPTH(NODES)) u_code_ram (
      .clock(clock), .wr_en(cd_we), .wr_addr(cd_wa), .wr_data(cd_wd),
      .rd_addr(cd_ra), .rd_data(cd_rd)
   );

   // compare in the insert scan, add in the merge
   assign alu_a = (state_ff == ST_MRG_B) ? a_ent_ff[SUM_W-1:0] : srt_rd[SUM_W-1:0];

   hcb_alu #(.SUM_W(SUM_W)) u_alu (
      .a_freq(alu_a), .b_freq(srt_rd[SUM_W-1:0]), .key_freq(key_freq_ff),
      .sum_freq(alu_sum), .a_greater(alu_gt)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign tail       = head_ff + NODE_W'(len_ff);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_code_ff[CODE_W-1:0], out_code_ff[CE_W-1:CODE_W], out_sym_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      head_in      = head_ff;
      merge_in     = merge_ff;
      walk_in      = walk_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      build_in     = build_ff;
      out_valid_in = out_valid_ff;
      pos_in       = pos_ff;
      key_node_in  = key_node_ff;
      key_freq_in  = key_freq_ff;
      a_ent_in     = a_ent_ff;
      par_in       = par_ff;
      right_in     = right_ff;
      out_sym_in   = out_sym_ff;
      out_code_in  = out_code_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      srt_we = 1'b0;
      srt_wa = pos_ff;
      srt_wd = {key_node_ff, key_freq_ff};
      srt_ra = pos_ff - NODE_W'(1);
      ch_we  = 1'b0;
      ch_wa  = merge_ff[CH_AW-1:0];
      ch_wd  = {a_ent_ff[ENT_W-1:SUM_W], srt_rd[ENT_W-1:SUM_W]};
      ch_ra  = walk_ff[CH_AW-1:0];
      cd_we  = 1'b0;
      cd_wa  = NODE_W'(count_ff) + NODE_W'(merge_ff) - NODE_W'(1);
      cd_wd  = '0;
      cd_ra  = NODE_W'(count_ff) + NODE_W'(walk_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               last_in = req_tlast;
               if (count_ff < CNT_W'(MAX_SYMBOLS)) begin
                  key_freq_in = SUM_W'(req_tdata[FREQ_W-1:0]);
                  key_node_in = NODE_W'(count_ff);
                  pos_in      = tail;
                  state_in    = ST_INS_RD;
               end else begin
                  ovf_in = 1'b1;
                  if (req_tlast) begin
                     build_in = 1'b1;
                     state_in = ST_MRG_CHK;
                  end
               end
            end
         end
         ST_INS_RD, ST_INS_CMP: begin
            // scan backward from the tail, moving larger entries up one place
            if (state_ff == ST_INS_CMP && alu_gt) begin
               srt_we   = 1'b1;
               srt_wd   = srt_rd;
               pos_in   = pos_ff - NODE_W'(1);
               state_in = ST_INS_RD;
            end else if (state_ff == ST_INS_RD && pos_ff != head_ff) begin
               state_in = ST_INS_CMP;
            end else begin
               srt_we = 1'b1;
               len_in = len_ff + CNT_W'(1);
               if (build_ff) begin
                  merge_in = merge_ff + CNT_W'(1);
                  state_in = ST_MRG_CHK;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  if (last_ff) begin
                     build_in = 1'b1;
                     state_in = ST_MRG_CHK;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_MRG_CHK: begin
            srt_ra = head_ff;
            if (len_ff < CNT_W'(2)) begin
               state_in = ST_CODE_INIT;
            end else begin
               state_in = ST_MRG_A;
            end
         end
         ST_MRG_A: begin
            a_ent_in = srt_rd;
            srt_ra   = head_ff + NODE_W'(1);
            state_in = ST_MRG_B;
         end
         ST_MRG_B: begin
            // front two leave the list, their parent is inserted in sorted order, scanning from the tail
            ch_we       = 1'b1;
            key_freq_in = alu_sum;
            key_node_in = NODE_W'(count_ff) + NODE_W'(merge_ff);
            pos_in      = tail;
            head_in     = head_ff + NODE_W'(2);
            len_in      = len_ff - CNT_W'(2);
            state_in    = ST_INS_RD;
         end
         ST_CODE_INIT: begin
            // root gets the empty code; a lone symbol is its own root
            cd_we    = 1'b1;
            walk_in  = merge_ff - CNT_W'(1);
            if (merge_ff == '0) begin
               walk_in  = '0;
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_CODE_RD;
            end
         end
         ST_CODE_RD: begin
            state_in = ST_CODE_L;
         end
         ST_CODE_L: begin
            par_in   = {cd_rd[CE_W-1:CODE_W] + LEN_W'(1), cd_rd[CODE_W-2:0], 1'b0};
            right_in = ch_rd[NODE_W-1:0];
            cd_we    = 1'b1;
            cd_wa    = ch_rd[2*NODE_W-1:NODE_W];
            cd_wd    = {cd_rd[CE_W-1:CODE_W] + LEN_W'(1), cd_rd[CODE_W-2:0], 1'b0};
            state_in = ST_CODE_R;
         end
         ST_CODE_R: begin
            cd_we = 1'b1;
            cd_wa = right_ff;
            cd_wd = {par_ff[CE_W-1:1], 1'b1};
            if (walk_ff == '0) begin
               state_in = ST_EMIT_RD;
            end else begin
               walk_in  = walk_ff - CNT_W'(1);
               state_in = ST_CODE_RD;
            end
         end
         ST_EMIT_RD: begin
            cd_ra    = NODE_W'(walk_ff);
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            out_sym_in   = SYM_W'(walk_ff);
            out_code_in  = cd_rd;
            out_last_in  = (walk_ff == count_ff - CNT_W'(1));
            out_ovf_in   = ovf_ff;
            out_valid_in = 1'b1;
            state_in     = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (rsp_tready) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  count_in = '0;
                  len_in   = '0;
                  head_in  = '0;
                  merge_in = '0;
                  walk_in  = '0;
                  ovf_in   = 1'b0;
                  last_in  = 1'b0;
                  build_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  walk_in  = walk_ff + CNT_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         len_ff       <= '0;
         head_ff      <= '0;
         merge_ff     <= '0;
         walk_ff      <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         build_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         head_ff      <= head_in;
         merge_ff     <= merge_in;
         walk_ff      <= walk_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         build_ff     <= build_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      key_node_ff <= key_node_in;
      key_freq_ff <= key_freq_in;
      a_ent_ff    <= a_ent_in;
      par_ff      <= par_in;
      right_ff    <= right_in;
      out_sym_ff  <= out_sym_in;
      out_code_ff <= out_code_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

endmodule

/* tb/sv/huffman_code_builder_tb.sv */
// self-checking testbench for the huffman code builder
// depends on hcb_pkg and the huffman_code_builder rtl; predicts codes in a local tree model
`timescale 1ns / 100ps

module huffman_code_builder_tb;
   import hcb_pkg::*;

   localparam int NSYM      = DEF_MAX_SYMBOLS;
   localparam int NNODE     = 2 * NSYM - 1;
   localparam int CYCLE_CAP = 3000000;

   typedef struct packed {
      logic [SYM_W-1:0]  sym;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
      logic              last;
      logic              ovf;
   } code_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   huffman_code_builder dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   // predictor state: the current set of leaf frequencies
   logic [29:0]   leaf_freq [NSYM];
   int            leaf_count = 0;
   bit            dropped_any = 0;
   code_word_type pending_codes [$];

   int n_items = 0, n_codes = 0, n_sets = 0, n_errors = 0;
   int cycles = 0;
   bit hold_off = 0;

   // build the tree for the held set and queue one code per symbol
   task automatic predict_codes();
      logic [29:0] nf [NNODE];
      logic [6:0]  ord [NSYM];
      logic [6:0]  lch [NSYM], rch [NSYM];
      logic [CODE_W-1:0] cb [NNODE];
      int cl [NNODE];
      int n, len, k, pos, p;
      code_word_type w;
      n = leaf_count;
      len = 0;
      for (int i = 0; i < n; i++) begin
         nf[i] = leaf_freq[i];
         pos = 0;
         while (pos < len && nf[ord[pos]] <= nf[i]) pos++;
         for (int j = len; j > pos; j--) ord[j] = ord[j-1];
         ord[pos] = 7'(i);
         len++;
      end
      k = 0;
      while (len >= 2) begin
         p = n + k;
         lch[k] = ord[0];
         rch[k] = ord[1];
         nf[p] = nf[ord[0]] + nf[ord[1]];
         for (int j = 0; j < len - 2; j++) ord[j] = ord[j+2];
         len -= 2;
         pos = 0;
         while (pos < len && nf[ord[pos]] <= nf[p]) pos++;
         for (int j = len; j > pos; j--) ord[j] = ord[j-1];
         ord[pos] = 7'(p);
         len++;
         k++;
      end
      for (int i = 0; i < NNODE; i++) begin
         cb[i] = '0;
         cl[i] = 0;
      end
      for (int m = k - 1; m >= 0; m--) begin
         p = n + m;
         cb[lch[m]] = cb[p] << 1;
         cl[lch[m]] = cl[p] + 1;
         cb[rch[m]] = (cb[p] << 1) | CODE_W'(1);
         cl[rch[m]] = cl[p] + 1;
      end
      for (int i = 0; i < n; i++) begin
         w.sym = SYM_W'(i); w.len = LEN_W'(cl[i]); w.bits = cb[i];
         w.last = (i == n - 1); w.ovf = dropped_any;
         pending_codes.push_back(w);
      end
      leaf_count = 0;
      dropped_any = 0;
      n_sets++;
   endtask

   // one frequency transfer, with a random gap in front; valid stays high if no gap follows
   task automatic send_freq(input logic [23:0] f, input bit lst);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= f;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_items++;
      if (leaf_count < NSYM) begin
         leaf_freq[leaf_count] = 30'(f);
         leaf_count++;
      end else begin
         dropped_any = 1;
      end
      if (lst) predict_codes();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_set(input int n, input int maxf);
      for (int i = 0; i < n; i++)
         send_freq(24'($urandom_range(0, maxf)), i == n - 1);
   endtask

   // lone symbols, extremes of the frequency, small sets of two to four symbols
   task automatic test_directed();
      send_freq(24'h000000, 1);
      send_freq(24'hFFFFFF, 1);
      send_freq(24'hFFFFFF, 0);
      send_freq(24'hFFFFFF, 1);
      send_freq(24'h000000, 0);
      send_freq(24'h000000, 0);
      send_freq(24'h000000, 1);
      send_freq(24'h555555, 0);
      send_freq(24'hAAAAAA, 0);
      send_freq(24'h000001, 0);
      send_freq(24'h000001, 1);
      // skewed frequencies give a deep chain
      for (int i = 0; i < 10; i++) send_freq(24'd1 << (2 * i), i == 9);
      wait_drained();
   endtask

   // full capacity, then loads beyond it (the last one dropped too)
   task automatic test_overflow();
      send_set(NSYM, 24'hFFFFFF);
      wait_drained();
      for (int i = 0; i < NSYM + 3; i++)
         send_freq(24'($urandom_range(0, 1000)), i == NSYM + 2);
      wait_drained();
   endtask

   // receiver holds off while a second set is offered, so the block backs up
   task automatic test_backpressure();
      hold_off = 1;
      send_set(12, 50);
      send_set(5, 50);
      wait_drained();
   endtask

   // random sets, mostly small, a few fibonacci sets for the longest codes
   task automatic test_random();
      int n, a, b, t;
      while (n_items < 410) begin
         case ($urandom_range(0, 9))
            0: begin
               n = 40;
               a = 1;
               b = 1;
               for (int i = 0; i < n; i++) begin
                  send_freq(24'(a), i == n - 1);
                  t = a + b; a = b; b = (t > 24'hFFFFFF) ? 24'hFFFFFF : t;
               end
            end
            1, 2:    send_set($urandom_range(1, 64), 24'hFFFFFF);
            3, 4, 5: send_set($urandom_range(1, 8), 3);
            default: send_set($urandom_range(2, 16), $urandom_range(1, 1000));
         endcase
      end
      wait_drained();
   endtask

   // receiver stalls: random, plus one long hold-off counted in cycles
   initial begin
      int stall;
      stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
               stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(1, 3);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      code_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.sym  = rsp_tdata[5:0];
         got.len  = rsp_tdata[11:6];
         got.bits = rsp_tdata[74:12];
         got.last = rsp_tlast;
         got.ovf  = rsp_tuser;
         n_codes++;
         if (pending_codes.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected code transfer: %p", got);
         end else begin
            want = pending_codes.pop_front();
            if (got !== want || rsp_tdata[79:75] !== '0) begin
               n_errors++;
               if (n_errors <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("FAIL huffman_code_builder");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_backpressure();
      test_random();
      if (pending_codes.size() != 0) n_errors++;
      $display("ran %0d frequency transfers in %0d sets, checked %0d codes", n_items, n_sets,
               n_codes);
      $display("covered lone symbols, capacity overflow, long stalls and deep trees");
      if (n_errors == 0) begin
         $display("PASS huffman_code_builder");
      end else begin
         $display("FAIL huffman_code_builder");
      end
      $finish;
   end

endmodule
